@@ sv/programmable_fsm_table_engine_top_assert.svh @@
// ----------------------------------------------------------------------------
// programmable fsm table engine assertion macros
// concurrent checks clocked on clock, held off while reset is high
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_FSM_TABLE_ENGINE_TOP_ASSERT_SVH
`define PROGRAMMABLE_FSM_TABLE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PFSM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pfsm_pkg.sv @@
// ----------------------------------------------------------------------------
// pfsm_pkg
// types, codes and sizes shared by the programmable fsm table engine
// ----------------------------------------------------------------------------
package pfsm_pkg;

   // table geometry
   localparam int STATE_CAP   = 16;
   localparam int EVENT_CAP   = 16;
   localparam int ACTION_BITS = 4;
   localparam int CELL_COUNT  = STATE_CAP * EVENT_CAP;
   localparam int ADDR_BITS   = $clog2(CELL_COUNT);

   // field widths
   localparam int KIND_BITS      = 3;
   localparam int STATE_BITS     = 4;
   localparam int EVENT_BITS     = 4;
   localparam int CFG_BITS       = 5;
   localparam int CSR_INDEX_BITS = 1;
   // cell layout: valid mark, next state, action
   localparam int CELL_BITS      = 1 + STATE_BITS + ACTION_BITS;

   // request kinds
   localparam logic [KIND_BITS-1:0] KIND_EVENT       = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_WRITE       = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_FORCE       = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_RESET_STATE = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR       = 3'd4;

   // result status
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_STATES = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_EVENTS = 1'b1;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [EVENT_BITS-1:0]  event_req;
      logic [STATE_BITS-1:0]  state_index;
      logic [STATE_BITS-1:0]  dest_state;
      logic [ACTION_BITS-1:0] action_code;
   } req_payload_type;

   typedef struct packed {
      logic                   status;
      logic [STATE_BITS-1:0]  present_state;
      logic                   action_fired;
      logic [ACTION_BITS-1:0] action_out;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LOOK  = 3'b010,
      ST_CLEAR = 3'b100
   } seq_state_type;

   // flat table address of a (state, event) cell
   function automatic logic [ADDR_BITS-1:0] cell_index(
      input logic [STATE_BITS-1:0] s,
      input logic [EVENT_BITS-1:0] e
   );
      cell_index = ADDR_BITS'(s) * ADDR_BITS'(EVENT_CAP) + ADDR_BITS'(e);
   endfunction

endpackage

@@ sv/pfsm_ram.sv @@
// ----------------------------------------------------------------------------
// pfsm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pfsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/programmable_fsm_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// programmable_fsm_table_engine_top
// table-driven state machine with a programmable transition table
// ----------------------------------------------------------------------------
// channels: req_ carries one command beat (event, transition write, force,
// state reset, table clear); rsp_ returns exactly one result beat per
// command; csr_ writes num_states (index 0) and num_events (index 1), always
// ready; the user must write it only while no command is in flight (not
// enforced). table: one 256 x 9 ram (valid mark, next state, action) with
// a registered read; an event reads the cell at the current state and
// event. results: an event's result is registered after the ram read and
// the ST_LOOK step that applies the cell; every other command shows its
// result the cycle after accept. throughput: an event holds off new beats
// until its lookup is done; other commands but a clear, one per cycle while
// rsp_ready is high. table clear: the result comes the cycle after accept,
// then a walk writes all 256 cells, holding req_ready low while it runs.
// the result register decouples the channels: a new beat is taken while the
// previous result is being taken; when rsp_ready stays low the block holds
// the result and stops taking beats. reset: state 0, both counts 16; when
// reset drops the walk clears all valid marks before the first beat.
// ----------------------------------------------------------------------------
`include "programmable_fsm_table_engine_top_assert.svh"

module programmable_fsm_table_engine_top
   import pfsm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   // control state
   seq_state_type          state_ff, state_in;
   logic [STATE_BITS-1:0]  machine_state_ff, machine_state_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [CFG_BITS-1:0]    num_states_ff, num_events_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;
   logic                   look_ok_ff, look_ok_in;

   // request decode
   logic                   out_free;
   logic                   req_fire;
   logic                   ev_ok, st_ok, nx_ok;
   logic                   wr_ok;
   logic                   clearing;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   rd_addr, wr_addr;
   logic [CELL_BITS-1:0]   wr_data, rd_data;
   logic                   cell_valid;
   logic [STATE_BITS-1:0]  cell_next;
   logic [ACTION_BITS-1:0] cell_action;
   logic                   look_hit;
   logic                   look_miss;

   // result slot is free if empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   // range checks against the programmed counts
   assign ev_ok = {1'b0, req_payload.event_req}   < num_events_ff;
   assign st_ok = {1'b0, req_payload.state_index} < num_states_ff;
   assign nx_ok = {1'b0, req_payload.dest_state}  < num_states_ff;
   assign wr_ok = (req_payload.kind == KIND_WRITE) && st_ok && ev_ok && nx_ok;

   // table access: read at current state, write at the named source state,
   // or at the walk address while the table is being cleared
   assign clearing = (state_ff == ST_CLEAR);
   assign rd_addr  = cell_index(machine_state_ff, req_payload.event_req);
   assign wr_addr  = clearing ? clr_addr_ff
                              : cell_index(req_payload.state_index, req_payload.event_req);
   assign wr_data  = clearing ? '0
                              : {1'b1, req_payload.dest_state, req_payload.action_code};
   assign wr_en    = clearing || (req_fire && wr_ok);

   pfsm_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (CELL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // cell fields as read back in the cycle after the event was taken
   assign cell_valid  = rd_data[CELL_BITS-1];
   assign cell_next   = rd_data[ACTION_BITS +: STATE_BITS];
   assign cell_action = rd_data[ACTION_BITS-1:0];
   assign look_hit    = look_ok_ff && cell_valid;
   assign look_miss   = (state_ff == ST_LOOK) && !look_hit;

   always_comb begin
      state_in         = state_ff;
      machine_state_in = machine_state_ff;
      clr_addr_in      = clr_addr_ff;
      look_ok_in       = look_ok_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_payload_in   = rsp_payload_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_payload_in.status       = STATUS_REJECT;
               rsp_payload_in.action_fired = 1'b0;
               rsp_payload_in.action_out   = '0;
               case (req_payload.kind)
                  KIND_EVENT: begin
                     // capture the range check, cell data comes next cycle
                     look_ok_in = ev_ok;
                     state_in   = ST_LOOK;
                  end
                  KIND_WRITE: begin
                     if (wr_ok) begin
                        rsp_payload_in.status = STATUS_OK;
                     end
                  end
                  KIND_FORCE: begin
                     if (st_ok) begin
                        machine_state_in      = req_payload.state_index;
                        rsp_payload_in.status = STATUS_OK;
                     end
                  end
                  KIND_RESET_STATE: begin
                     machine_state_in      = '0;
                     rsp_payload_in.status = STATUS_OK;
                  end
                  KIND_CLEAR: begin
                     // answer now, then walk every cell
                     machine_state_in      = '0;
                     clr_addr_in           = '0;
                     state_in              = ST_CLEAR;
                     rsp_payload_in.status = STATUS_OK;
                  end
                  default: begin
                     // unknown kind: rejected, nothing changes
                  end
               endcase
               rsp_payload_in.present_state = machine_state_in;
               if (req_payload.kind != KIND_EVENT) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_LOOK: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (look_hit) begin
               machine_state_in            = cell_next;
               rsp_payload_in.status       = STATUS_OK;
               rsp_payload_in.action_out   = cell_action;
               rsp_payload_in.action_fired = (cell_action != '0);
            end
            rsp_payload_in.present_state = machine_state_in;
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_BITS'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         machine_state_ff <= '0;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         machine_state_ff <= machine_state_in;
         clr_addr_ff      <= clr_addr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      look_ok_ff     <= look_ok_in;
   end

   // configuration registers, out-of-range values are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= CFG_BITS'(STATE_CAP);
         num_events_ff <= CFG_BITS'(EVENT_CAP);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_STATES: begin
               if (csr_wdata != '0 && csr_wdata <= CFG_BITS'(STATE_CAP)) begin
                  num_states_ff <= csr_wdata;
               end
            end
            CSR_NUM_EVENTS: begin
               if (csr_wdata != '0 && csr_wdata <= CFG_BITS'(EVENT_CAP)) begin
                  num_events_ff <= csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a lookup always ends in a result beat
   `PFSM_ASSERT_NEXT(a_look_gives_rsp, state_ff == ST_LOOK, rsp_valid_ff, "lookup gave no result")
   // no new beat while a lookup or a clear walk is running
   `PFSM_ASSERT_NOW(a_busy_no_accept, state_ff != ST_IDLE, !req_ready, "beat taken while busy")
   // non-event commands answer on the next cycle
   `PFSM_ASSERT_NEXT(a_direct_rsp, req_fire && state_in != ST_LOOK, rsp_valid_ff, "result missing")
   // a rejected event leaves the machine state alone
   `PFSM_ASSERT_NEXT(a_miss_holds_state, look_miss, $stable(machine_state_ff), "rejected event moved state")

endmodule

@@ test/tb_programmable_fsm_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_programmable_fsm_table_engine_top
// self-checking bench for the programmable table-driven state machine. a
// directed burst walks the corner cases. random phases then run under
// different state and event counts, with random gaps on both channels, one
// stretch with no gaps and one long result hold-off. every result beat is
// checked field by field against a predictor that is fed the accepted beats.
// ----------------------------------------------------------------------------
module tb_programmable_fsm_table_engine_top import pfsm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 31;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 8;

   // kinds the block has to ignore
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN_FIRST = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN_LAST  = 3'd7;

   // predictor of the machine plus the queue of results it has worked out
   class transition_checker;
      logic [CFG_BITS-1:0]    state_count;
      logic [CFG_BITS-1:0]    event_count;
      logic [STATE_BITS-1:0]  cur_state;
      bit                     cell_valid  [CELL_COUNT];
      logic [STATE_BITS-1:0]  cell_next   [CELL_COUNT];
      logic [ACTION_BITS-1:0] cell_action [CELL_COUNT];
      rsp_payload_type        predicted_results [$];
      int                     failures;

      function new();
         state_count = CFG_BITS'(STATE_CAP);
         event_count = CFG_BITS'(EVENT_CAP);
         cur_state   = '0;
         failures    = 0;
         wipe_cells();
      endfunction

      function void wipe_cells();
         for (int i = 0; i < CELL_COUNT; i++) begin
            cell_valid[i]  = 1'b0;
            cell_next[i]   = '0;
            cell_action[i] = '0;
         end
      endfunction

      function int cell_of(logic [STATE_BITS-1:0] s, logic [EVENT_BITS-1:0] e);
         return int'(s) * EVENT_CAP + int'(e);
      endfunction

      // out of range values leave the register as it was
      function void apply_register_write(logic [CSR_INDEX_BITS-1:0] index,
                                         logic [CFG_BITS-1:0] value);
         case (index)
            CSR_NUM_STATES: begin
               if (value != 0 && value <= STATE_CAP) state_count = value;
            end
            CSR_NUM_EVENTS: begin
               if (value != 0 && value <= EVENT_CAP) event_count = value;
            end
            default: ;
         endcase
      endfunction

      function void predict_step(req_payload_type cmd);
         rsp_payload_type r;
         int              idx;
         r        = '0;
         r.status = STATUS_REJECT;
         case (cmd.kind)
            KIND_EVENT: begin
               // looked up at the current state even if it is above the count
               if (cmd.event_req < event_count) begin
                  idx = cell_of(cur_state, cmd.event_req);
                  if (cell_valid[idx]) begin
                     r.status       = STATUS_OK;
                     r.action_out   = cell_action[idx];
                     r.action_fired = (cell_action[idx] != 0);
                     cur_state      = cell_next[idx];
                  end
               end
            end
            KIND_WRITE: begin
               if (cmd.state_index < state_count && cmd.event_req < event_count &&
                   cmd.dest_state < state_count) begin
                  idx              = cell_of(cmd.state_index, cmd.event_req);
                  cell_valid[idx]  = 1'b1;
                  cell_next[idx]   = cmd.dest_state;
                  cell_action[idx] = cmd.action_code;
                  r.status         = STATUS_OK;
               end
            end
            KIND_FORCE: begin
               if (cmd.state_index < state_count) begin
                  cur_state = cmd.state_index;
                  r.status  = STATUS_OK;
               end
            end
            KIND_RESET_STATE: begin
               cur_state = '0;
               r.status  = STATUS_OK;
            end
            KIND_CLEAR: begin
               cur_state = '0;
               wipe_cells();
               r.status  = STATUS_OK;
            end
            default: ;
         endcase
         r.present_state = cur_state;
         predicted_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         failures++;
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (predicted_results.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing expected", got));
         end else begin
            want = predicted_results.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         got.status, want.status));
            if (got.present_state !== want.present_state)
               report_mismatch($sformatf("present_state %0d, expected %0d",
                                         got.present_state, want.present_state));
            if (got.action_fired !== want.action_fired)
               report_mismatch($sformatf("action_fired %0d, expected %0d",
                                         got.action_fired, want.action_fired));
            if (got.action_out !== want.action_out)
               report_mismatch($sformatf("action_out %0d, expected %0d",
                                         got.action_out, want.action_out));
         end
      endtask
   endclass

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CFG_BITS-1:0]       csr_wdata   = '0;

   transition_checker table_model;
   bit                sender_idles    = 1'b1;
   bit                receiver_stalls = 1'b1;
   bit                hold_armed      = 1'b0;
   int unsigned       cycle_count     = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   programmable_fsm_table_engine_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // every handshake is sampled at the rising edge; the predictor moves on
   // accepted beats, so its state always matches what the block has taken
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) table_model.apply_register_write(csr_index, csr_wdata);
         if (req_valid && req_ready) table_model.predict_step(req_payload);
         if (rsp_valid && rsp_ready) table_model.check_result(rsp_payload);
      end
   end

   // watchdog, also catches a result that never shows up
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stalls, and one long hold-off when armed so the
   // block fills up and has to stall its request side
   initial begin
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= !receiver_stalls || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // mostly well-formed traffic: events that hit a written cell from the
   // current state and in-range writes, with a share of rejects and noise
   function automatic req_payload_type random_command();
      req_payload_type cmd;
      int              pick;
      int              tries;
      cmd.kind        = KIND_EVENT;
      cmd.event_req   = EVENT_BITS'($urandom_range(EVENT_CAP - 1));
      cmd.state_index = STATE_BITS'($urandom_range(STATE_CAP - 1));
      cmd.dest_state  = STATE_BITS'($urandom_range(STATE_CAP - 1));
      cmd.action_code = ACTION_BITS'($urandom_range((1 << ACTION_BITS) - 1));
      pick = int'($urandom_range(99));
      if (pick < 50) begin
         cmd.kind = KIND_EVENT;
         if ($urandom_range(99) < 90) begin
            cmd.event_req = EVENT_BITS'($urandom_range(table_model.event_count - 1));
            tries = 0;
            while (tries < 8 && !table_model.cell_valid[
                      table_model.cell_of(table_model.cur_state, cmd.event_req)]) begin
               cmd.event_req = EVENT_BITS'($urandom_range(table_model.event_count - 1));
               tries++;
            end
         end
      end else if (pick < 75) begin
         cmd.kind = KIND_WRITE;
         if ($urandom_range(99) < 85) begin
            // lean on the current state so the walk finds its way out
            cmd.state_index = ($urandom_range(99) < 40) ? table_model.cur_state :
                              STATE_BITS'($urandom_range(table_model.state_count - 1));
            cmd.event_req   = EVENT_BITS'($urandom_range(table_model.event_count - 1));
            cmd.dest_state  = STATE_BITS'($urandom_range(table_model.state_count - 1));
         end
      end else if (pick < 83) begin
         cmd.kind = KIND_FORCE;
      end else if (pick < 88) begin
         cmd.kind = KIND_RESET_STATE;
      end else if (pick < 89) begin
         cmd.kind = KIND_CLEAR;
      end else if (pick < 93) begin
         cmd.kind = KIND_BITS'($urandom_range(KIND_UNKNOWN_LAST, KIND_UNKNOWN_FIRST));
      end else begin
         cmd.kind = KIND_BITS'($urandom_range(KIND_UNKNOWN_LAST));
      end
      return cmd;
   endfunction

   // one request beat; a random one is drawn at the falling edge so the
   // predictor has already seen every earlier beat
   task automatic offer_command(input req_payload_type cmd, input bit pick_random);
      @(negedge clock);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      if (pick_random) cmd = random_command();
      req_valid   <= 1'b1;
      req_payload <= cmd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_command(input logic [KIND_BITS-1:0] kind,
                               input logic [EVENT_BITS-1:0] ev,
                               input logic [STATE_BITS-1:0] st,
                               input logic [STATE_BITS-1:0] nx,
                               input logic [ACTION_BITS-1:0] act);
      req_payload_type cmd;
      cmd.kind        = kind;
      cmd.event_req   = ev;
      cmd.state_index = st;
      cmd.dest_state  = nx;
      cmd.action_code = act;
      offer_command(cmd, 1'b0);
   endtask

   // drop valid and let every result in flight come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (table_model.predicted_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [CFG_BITS-1:0] states,
                            input logic [CFG_BITS-1:0] events,
                            input int beats, input bit wipe_first);
      wait_idle();
      write_register(CSR_NUM_STATES, states);
      write_register(CSR_NUM_EVENTS, events);
      if (wipe_first) send_command(KIND_CLEAR, '0, '0, '0, '0);
      repeat (beats) offer_command('0, 1'b1);
   endtask

   initial begin
      table_model = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extreme cells, no-action cell, force/reset
      send_command(KIND_EVENT, 4'd0, 4'd0, 4'd0, 4'd0);
      send_command(KIND_EVENT, 4'd15, 4'd15, 4'd15, 4'd15);
      send_command(KIND_WRITE, 4'd0, 4'd0, 4'd15, 4'd15);
      send_command(KIND_WRITE, 4'd15, 4'd15, 4'd0, 4'd0);
      send_command(KIND_WRITE, 4'd3, 4'd15, 4'd7, 4'd0);
      send_command(KIND_EVENT, 4'd0, 4'd0, 4'd0, 4'd0);
      send_command(KIND_EVENT, 4'd3, 4'd0, 4'd0, 4'd0);
      send_command(KIND_FORCE, 4'd0, 4'd15, 4'd0, 4'd0);
      send_command(KIND_EVENT, 4'd15, 4'd0, 4'd0, 4'd0);
      send_command(KIND_FORCE, 4'd0, 4'd9, 4'd0, 4'd0);
      send_command(KIND_RESET_STATE, 4'd15, 4'd15, 4'd15, 4'd15);
      send_command(KIND_UNKNOWN_FIRST, 4'd15, 4'd15, 4'd15, 4'd15);
      send_command(KIND_UNKNOWN_LAST, 4'd15, 4'd15, 4'd15, 4'd15);
      // clear drops every valid mark, so the same event now bounces
      send_command(KIND_CLEAR, 4'd0, 4'd0, 4'd0, 4'd0);
      send_command(KIND_EVENT, 4'd0, 4'd0, 4'd0, 4'd0);

      // small counts: range rejects on every field of write, force and event
      wait_idle();
      write_register(CSR_NUM_STATES, 5'd4);
      write_register(CSR_NUM_EVENTS, 5'd4);
      send_command(KIND_WRITE, 4'd0, 4'd4, 4'd1, 4'd1);
      send_command(KIND_WRITE, 4'd4, 4'd0, 4'd1, 4'd1);
      send_command(KIND_WRITE, 4'd0, 4'd0, 4'd4, 4'd1);
      send_command(KIND_FORCE, 4'd0, 4'd4, 4'd0, 4'd0);
      send_command(KIND_WRITE, 4'd3, 4'd3, 4'd3, 4'd5);
      send_command(KIND_FORCE, 4'd0, 4'd3, 4'd0, 4'd0);
      send_command(KIND_EVENT, 4'd4, 4'd0, 4'd0, 4'd0);
      // shrink the state count under the current state, lookup stays there
      wait_idle();
      write_register(CSR_NUM_STATES, 5'd2);
      send_command(KIND_EVENT, 4'd3, 4'd0, 4'd0, 4'd0);

      // random phases, full size first and last, extremes and bad writes between
      run_phase(5'd16, 5'd16, 240, 1'b0);
      run_phase(5'd1, 5'd1, 150, 1'b1);
      run_phase(5'd16, 5'd1, 150, 1'b0);
      run_phase(5'd1, 5'd16, 150, 1'b0);
      // zero and above-max writes are dropped, counts stay at 1 and 16
      run_phase(5'd0, 5'd17, 100, 1'b0);

      // long stretch with no gaps on either side
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      run_phase(5'd5, 5'd7, 250, 1'b1);

      // hold results back while requests keep coming
      receiver_stalls = 1'b1;
      wait_idle();
      write_register(CSR_NUM_STATES, 5'd3);
      write_register(CSR_NUM_EVENTS, 5'd2);
      hold_armed = 1'b1;
      repeat (150) offer_command('0, 1'b1);
      sender_idles    = 1'b1;

      run_phase(5'd31, 5'd0, 100, 1'b0);
      run_phase(5'd16, 5'd16, 400, 1'b0);

      wait_idle();
      if (table_model.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
